### hw/rtl/akbt_pkg.sv
// Package for the action key binding table: item types, command codes and the
// structs that travel between the top level and the row of entry cells.
// No dependencies.
`default_nettype none

package akbt_pkg;

    // Default number of table entries.
    localparam int ENTRIES_DEFAULT = 64;

    // Request kinds.
    localparam logic [2:0] KIND_BIND_PRI = 3'd0;
    localparam logic [2:0] KIND_BIND_ALT = 3'd1;
    localparam logic [2:0] KIND_KEY      = 3'd2;
    localparam logic [2:0] KIND_TICK     = 3'd3;
    localparam logic [2:0] KIND_QUERY    = 3'd4;

    // Key event states.
    localparam logic [1:0] PRESS_RELEASE = 2'd0;
    localparam logic [1:0] PRESS_DOWN    = 2'd1;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] action_id;
        logic [9:0]  key;
        logic [1:0]  press_state;
    } t_in_item;

    typedef struct packed {
        logic        displaced_valid;
        logic [15:0] displaced_action;
        logic        action_down;
        logic        action_released;
        logic        table_full;
    } t_out_item;

    // Command broadcast from the sequencer to every cell.
    typedef struct packed {
        logic        match;      // compare phase: register hit bits
        logic        apply;      // update phase: write entry state
        logic [2:0]  kind;
        logic [15:0] action_id;
        logic [9:0]  key;
        logic [1:0]  press_state;
        logic        append;     // bind appends a new entry at the fill count
        logic        bind_go;    // bind goes ahead (entry found or room left)
    } t_cell_cmd;

    // Link handed from one cell to the next along the row.
    typedef struct packed {
        logic        id_seen;
        logic        key_seen;
        logic [15:0] disp_action;
        logic        down;
        logic        released;
    } t_link;

endpackage

`default_nettype wire

### hw/rtl/action_key_binding_table_unit.sv
// Top level of the action key binding table: sequencer, fill count, result
// register and the row of entry cells. Depends on akbt_pkg and akbt_cell.
//
// Usage. Requests come in on the input channel (i_in_valid, o_in_ready,
// i_in_item) and every request yields exactly one result item on the output
// channel (o_out_valid, i_out_ready, o_out_item). A request binds an action's
// primary or alternate key, reports a key press or release, marks a tick, or
// queries an action; every result carries the action's down and released
// flags after the request, and binds also report a displaced action or a
// full table.
//
// Sequence. The block takes one item at a time. An accepted item is compared in
// every cell, then applied, and its result is then loaded into the output
// register once that register is free; only then does the block take a new item.
// The four-phase sequencer (accept, compare, update, report) over the cell row
// steps through these phases; the first-match choice ripples down the row.
//
// Reset clears the fill count, every valid, bound and flag bit in the cells, and
// the output valid bit. When the receiver stalls, the finished result waits in
// the output register while the next item is accepted and worked on; that item
// then waits in its report phase until the register frees up.
`default_nettype none

module action_key_binding_table_unit #(
    parameter int ENTRIES = akbt_pkg::ENTRIES_DEFAULT
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  akbt_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output akbt_pkg::t_out_item  o_out_item
);

    localparam int CNT_W = $clog2(ENTRIES + 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_MATCH  = 4'b0010,
        ST_APPLY  = 4'b0100,
        ST_REPORT = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    akbt_pkg::t_in_item  r_req;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_disp_valid, n_disp_valid;
    logic [15:0]         r_disp_action, n_disp_action;
    logic                r_full, n_full;
    logic                r_out_valid, n_out_valid;
    akbt_pkg::t_out_item r_out_item;

    akbt_pkg::t_cell_cmd cmd;
    akbt_pkg::t_link     link [ENTRIES+1];

    logic is_bind;
    logic found;
    logic room;
    logic out_free;
    logic in_take;

    assign is_bind  = (r_req.kind == akbt_pkg::KIND_BIND_PRI) ||
                      (r_req.kind == akbt_pkg::KIND_BIND_ALT);
    assign found    = link[ENTRIES].id_seen;
    assign room     = (r_count != CNT_W'(ENTRIES));
    assign out_free = !r_out_valid || i_out_ready;
    assign in_take  = i_in_valid && o_in_ready;

    always_comb begin
        cmd.match       = (r_state == ST_MATCH);
        cmd.apply       = (r_state == ST_APPLY);
        cmd.kind        = r_req.kind;
        cmd.action_id   = r_req.action_id;
        cmd.key         = r_req.key;
        cmd.press_state = r_req.press_state;
        cmd.bind_go     = is_bind && (found || room);
        cmd.append      = is_bind && !found && room;
    end

    // The row of cells; the link carries first-match and gathered results.
    assign link[0] = '0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        akbt_cell #(
            .IDX   (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (cmd),
            .i_count (r_count),
            .i_link  (link[g]),
            .o_link  (link[g+1])
        );
    end

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_disp_valid  = r_disp_valid;
        n_disp_action = r_disp_action;
        n_full        = r_full;
        n_out_valid   = r_out_valid;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    n_state = ST_MATCH;
                end
            end
            ST_MATCH: begin
                n_state = ST_APPLY;
            end
            ST_APPLY: begin
                // Displacement applies only when the bind goes ahead.
                n_disp_valid  = cmd.bind_go && link[ENTRIES].key_seen;
                n_disp_action = link[ENTRIES].disp_action;
                n_full        = is_bind && !found && !room;
                if (cmd.append) begin
                    n_count = r_count + CNT_W'(1);
                end
                n_state = ST_REPORT;
            end
            ST_REPORT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_disp_valid  <= n_disp_valid;
        r_disp_action <= n_disp_action;
        r_full        <= n_full;
        if (in_take) begin
            r_req <= i_in_item;
        end
        if ((r_state == ST_REPORT) && out_free) begin
            r_out_item.displaced_valid  <= r_disp_valid;
            r_out_item.displaced_action <= r_disp_action;
            r_out_item.action_down      <= link[ENTRIES].down;
            r_out_item.action_released  <= link[ENTRIES].released;
            r_out_item.table_full       <= r_full;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

### hw/rtl/akbt_cell.sv
// One entry cell of the action key binding table.
// Depends on akbt_pkg for the command and link structs and the kind codes.
`default_nettype none

module akbt_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 7
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  akbt_pkg::t_cell_cmd     i_cmd,
    input  wire  [CNT_W-1:0]        i_count,
    input  akbt_pkg::t_link         i_link,
    output akbt_pkg::t_link         o_link
);

    logic        r_used, n_used;
    logic [15:0] r_action, n_action;
    logic [9:0]  r_pcode, n_pcode;
    logic        r_pbound, n_pbound;
    logic [9:0]  r_acode, n_acode;
    logic        r_abound, n_abound;
    logic        r_held, n_held;
    logic        r_pend, n_pend;
    logic        r_seen, n_seen;
    logic        r_id_hit, n_id_hit;
    logic        r_phit, n_phit;
    logic        r_ahit, n_ahit;

    logic new_here;
    logic target;
    logic key_hit;
    logic other_hit;
    logic disp_here;
    logic rep_hit;
    logic is_alt;
    logic key_event;

    assign new_here  = i_cmd.append && (i_count == CNT_W'(IDX));
    assign target    = r_id_hit || new_here;
    assign key_hit   = r_phit || r_ahit;
    assign other_hit = !r_id_hit && key_hit;
    assign disp_here = i_cmd.bind_go && other_hit && !i_link.key_seen;
    assign rep_hit   = r_used && (r_action == i_cmd.action_id);
    assign is_alt    = (i_cmd.kind == akbt_pkg::KIND_BIND_ALT);
    assign key_event = (i_cmd.kind == akbt_pkg::KIND_KEY) &&
                       ((i_cmd.press_state == akbt_pkg::PRESS_RELEASE) ||
                        (i_cmd.press_state == akbt_pkg::PRESS_DOWN));

    always_comb begin
        n_used   = r_used;
        n_action = r_action;
        n_pcode  = r_pcode;
        n_pbound = r_pbound;
        n_acode  = r_acode;
        n_abound = r_abound;
        n_held   = r_held;
        n_pend   = r_pend;
        n_seen   = r_seen;
        n_id_hit = r_id_hit;
        n_phit   = r_phit;
        n_ahit   = r_ahit;

        if (i_cmd.match) begin
            n_id_hit = r_used && (r_action == i_cmd.action_id);
            n_phit   = r_pbound && (r_pcode == i_cmd.key);
            n_ahit   = r_abound && (r_acode == i_cmd.key);
        end

        if (i_cmd.apply) begin
            if (i_cmd.bind_go && target) begin
                if (new_here) begin
                    n_used   = 1'b1;
                    n_action = i_cmd.action_id;
                    n_held   = 1'b0;
                    n_pend   = 1'b0;
                    n_seen   = 1'b0;
                end
                // The key leaves the other slot of the same action.
                if (is_alt) begin
                    n_pbound = !new_here && r_pbound && !r_phit;
                    n_acode  = i_cmd.key;
                    n_abound = 1'b1;
                end else begin
                    n_abound = !new_here && r_abound && !r_ahit;
                    n_pcode  = i_cmd.key;
                    n_pbound = 1'b1;
                end
            end
            if (disp_here) begin
                if (r_phit) begin
                    n_pbound = 1'b0;
                end else begin
                    n_abound = 1'b0;
                end
            end
            if (key_event && key_hit) begin
                if (i_cmd.press_state == akbt_pkg::PRESS_DOWN) begin
                    n_held = 1'b1;
                end else begin
                    n_held = 1'b0;
                    n_pend = 1'b1;
                end
            end
            if (i_cmd.kind == akbt_pkg::KIND_TICK) begin
                n_seen = r_pend;
                n_pend = 1'b0;
            end
        end
    end

    always_comb begin
        o_link.id_seen     = i_link.id_seen || r_id_hit;
        o_link.key_seen    = i_link.key_seen || other_hit;
        o_link.disp_action = i_link.disp_action | (disp_here ? r_action : 16'd0);
        o_link.down        = i_link.down || (rep_hit && r_held);
        o_link.released    = i_link.released || (rep_hit && r_seen);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= 1'b0;
            r_pbound <= 1'b0;
            r_abound <= 1'b0;
            r_held   <= 1'b0;
            r_pend   <= 1'b0;
            r_seen   <= 1'b0;
        end else begin
            r_used   <= n_used;
            r_pbound <= n_pbound;
            r_abound <= n_abound;
            r_held   <= n_held;
            r_pend   <= n_pend;
            r_seen   <= n_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action <= n_action;
        r_pcode  <= n_pcode;
        r_acode  <= n_acode;
        r_id_hit <= n_id_hit;
        r_phit   <= n_phit;
        r_ahit   <= n_ahit;
    end

endmodule

`default_nettype wire

### hw/rtl/akbt_checker.sv
// Port-level checker for the action key binding table, bound to the top level.
// Depends on akbt_pkg for the item types.
`default_nettype none

module akbt_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 i_in_valid,
    input wire                 o_in_ready,
    input akbt_pkg::t_in_item  i_in_item,
    input wire                 o_out_valid,
    input wire                 i_out_ready,
    input akbt_pkg::t_out_item o_out_item
);

    logic in_acc;
    assign in_acc = i_in_valid && o_in_ready;

    // A waiting result stays offered until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result item dropped before it was taken");

    // One item at a time: no new item right after one is accepted.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("input ready again right after an accepted item");

    // The result register is loaded in the report phase of an accepted item, or a
    // previous result still waits there, so valid is high when it is sampled.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> ##4 o_out_valid)
        else $error("no result three cycles after an accepted item");

    // A dropped bind never reports a displaced action.
    a_full_no_disp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.table_full) |->
            (!o_out_item.displaced_valid && (o_out_item.displaced_action == 16'd0)))
        else $error("full table result also reports a displacement");

    // The displaced id is zero whenever no displacement is reported.
    a_disp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.displaced_valid) |->
            (o_out_item.displaced_action == 16'd0))
        else $error("displaced action set without a displacement");

endmodule

bind action_key_binding_table_unit akbt_checker u_akbt_checker (.*);

`default_nettype wire

### tb/akbt_result_checker.sv
// Result checker for the action key binding table: watches both channels, keeps its own
// copy of the binding table and compares every result item with its prediction.
// Depends on akbt_pkg.
module akbt_result_checker #(
    parameter int ENTRIES = akbt_pkg::ENTRIES_DEFAULT
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    input  wire                  i_in_ready,
    input  akbt_pkg::t_in_item   i_in_item,
    input  wire                  i_out_valid,
    input  wire                  i_out_ready,
    input  akbt_pkg::t_out_item  i_out_item,
    output int                   o_fail_count,
    output int                   o_pending
);
    import akbt_pkg::*;

    logic        slot_used   [ENTRIES];
    logic [15:0] slot_action [ENTRIES];
    logic [9:0]  pri_code    [ENTRIES];
    logic        pri_on      [ENTRIES];
    logic [9:0]  alt_code    [ENTRIES];
    logic        alt_on      [ENTRIES];
    logic        held        [ENTRIES];
    logic        rel_pending [ENTRIES];
    logic        rel_seen    [ENTRIES];
    int          fill_count;

    t_out_item   awaited_results[$];
    t_out_item   want;
    int          failures = 0;

    // Lowest used slot that holds the action, or -1.
    function automatic int locate_action(input logic [15:0] id);
        int hit;
        hit = -1;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (slot_used[i] && slot_action[i] == id) begin
                hit = i;
            end
        end
        return hit;
    endfunction

    // Applies one request to the local table and returns the result item it yields.
    function automatic t_out_item binding_result(input t_in_item req);
        t_out_item res;
        int        idx;
        logic      taken;
        res   = '0;
        taken = 1'b0;
        if (req.kind == KIND_BIND_PRI || req.kind == KIND_BIND_ALT) begin
            idx = locate_action(req.action_id);
            if (idx < 0 && fill_count >= ENTRIES) begin
                res.table_full = 1'b1;
            end else begin
                if (idx < 0) begin
                    idx = fill_count;
                    fill_count++;
                    slot_used[idx]   = 1'b1;
                    slot_action[idx] = req.action_id;
                    pri_code[idx]    = '0;
                    alt_code[idx]    = '0;
                    pri_on[idx]      = 1'b0;
                    alt_on[idx]      = 1'b0;
                    held[idx]        = 1'b0;
                    rel_pending[idx] = 1'b0;
                    rel_seen[idx]    = 1'b0;
                end
                if (req.kind == KIND_BIND_ALT) begin
                    if (pri_on[idx] && pri_code[idx] == req.key) begin
                        pri_on[idx] = 1'b0;
                    end
                    alt_code[idx] = req.key;
                    alt_on[idx]   = 1'b1;
                end else begin
                    if (alt_on[idx] && alt_code[idx] == req.key) begin
                        alt_on[idx] = 1'b0;
                    end
                    pri_code[idx] = req.key;
                    pri_on[idx]   = 1'b1;
                end
                // Only the first other entry in table order loses the key.
                for (int i = 0; i < ENTRIES; i++) begin
                    if (!taken && slot_used[i] && slot_action[i] != req.action_id) begin
                        if (pri_on[i] && pri_code[i] == req.key) begin
                            pri_on[i] = 1'b0;
                            taken     = 1'b1;
                        end else if (alt_on[i] && alt_code[i] == req.key) begin
                            alt_on[i] = 1'b0;
                            taken     = 1'b1;
                        end
                        if (taken) begin
                            res.displaced_valid  = 1'b1;
                            res.displaced_action = slot_action[i];
                        end
                    end
                end
            end
        end else if (req.kind == KIND_KEY) begin
            if (req.press_state == PRESS_DOWN || req.press_state == PRESS_RELEASE) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (slot_used[i] && ((pri_on[i] && pri_code[i] == req.key) ||
                                         (alt_on[i] && alt_code[i] == req.key))) begin
                        if (req.press_state == PRESS_DOWN) begin
                            held[i] = 1'b1;
                        end else begin
                            held[i]        = 1'b0;
                            rel_pending[i] = 1'b1;
                        end
                    end
                end
            end
        end else if (req.kind == KIND_TICK) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (slot_used[i]) begin
                    rel_seen[i]    = rel_pending[i];
                    rel_pending[i] = 1'b0;
                end
            end
        end
        idx = locate_action(req.action_id);
        if (idx >= 0) begin
            res.action_down     = held[idx];
            res.action_released = rel_seen[idx];
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                slot_used[i]   = 1'b0;
                pri_on[i]      = 1'b0;
                alt_on[i]      = 1'b0;
                held[i]        = 1'b0;
                rel_pending[i] = 1'b0;
                rel_seen[i]    = 1'b0;
            end
            fill_count = 0;
            awaited_results.delete();
            o_pending <= 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                awaited_results.push_back(binding_result(i_in_item));
            end
            if (i_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    failures++;
                    if (failures <= 10) begin
                        $display("%0t: result item with none outstanding: %h", $time,
                                 i_out_item);
                    end
                end else begin
                    want = awaited_results.pop_front();
                    if (i_out_item.displaced_valid  !== want.displaced_valid  ||
                        i_out_item.displaced_action !== want.displaced_action ||
                        i_out_item.action_down      !== want.action_down      ||
                        i_out_item.action_released  !== want.action_released  ||
                        i_out_item.table_full       !== want.table_full) begin
                        failures++;
                        if (failures <= 10) begin
                            $display("%0t: mismatch, expected disp %b/%h down %b rel %b full %b",
                                     $time, want.displaced_valid, want.displaced_action,
                                     want.action_down, want.action_released, want.table_full);
                            $display("%0t:           actual   disp %b/%h down %b rel %b full %b",
                                     $time, i_out_item.displaced_valid,
                                     i_out_item.displaced_action, i_out_item.action_down,
                                     i_out_item.action_released, i_out_item.table_full);
                        end
                    end
                end
            end
            o_pending <= awaited_results.size();
        end
        o_fail_count <= failures;
    end

endmodule

### tb/action_key_binding_table_unit_test.sv
// Top of the action key binding table test: clock, reset, stimulus, receiver stalls and
// the verdict. Depends on akbt_pkg, action_key_binding_table_unit and akbt_result_checker.
module action_key_binding_table_unit_test;
    import akbt_pkg::*;

    localparam int TABLE_SLOTS     = ENTRIES_DEFAULT;
    localparam int RANDOM_ITEMS    = 1200;
    localparam int ID_POOL         = 80;
    localparam int NARROW_IDS      = 40;
    localparam int KEY_POOL        = 12;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int HOLD_OFF_AFTER  = 100;
    localparam int DRAIN_CYCLES    = 8;

    // Kinds and press states that the package leaves unnamed; the block must ignore them.
    localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [2:0] KIND_SPARE_MID   = 3'd6;
    localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;
    localparam logic [1:0] PRESS_IDLE_FIRST = 2'd2;
    localparam logic [1:0] PRESS_IDLE_LAST  = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    t_in_item    in_item;
    logic        out_valid;
    logic        out_ready;
    t_out_item   out_item;
    int          fail_count;
    int          pending;

    logic [15:0] id_pool  [ID_POOL];
    logic [9:0]  key_pool [KEY_POOL];
    int          burst_left;
    int          sent_count;
    int          phase_end;

    action_key_binding_table_unit #(
        .ENTRIES     (TABLE_SLOTS)
    ) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    akbt_result_checker #(
        .ENTRIES      (TABLE_SLOTS)
    ) checker_inst (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic t_in_item make_req(input logic [2:0] kind, input logic [15:0] id,
                                          input logic [9:0] key, input logic [1:0] ps);
        t_in_item r;
        r.kind        = kind;
        r.action_id   = id;
        r.key         = key;
        r.press_state = ps;
        return r;
    endfunction

    // Draws one request. Ids and keys come mostly from small pools so that binds collide,
    // key events hit bound slots and queries name actions that are in the table; a few
    // fully random ids and keys act as noise. id_span selects how much of the id pool is
    // in play, which decides whether the table can fill up.
    function automatic t_in_item random_request(input int id_span);
        t_in_item r;
        int       pick;
        r.action_id = id_pool[$urandom_range(0, id_span - 1)];
        if ($urandom_range(0, 19) == 0) begin
            r.action_id = 16'($urandom);
        end
        r.key = key_pool[$urandom_range(0, KEY_POOL - 1)];
        if ($urandom_range(0, 19) == 0) begin
            r.key = 10'($urandom);
        end
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            r.kind = KIND_BIND_PRI;
        end else if (pick < 35) begin
            r.kind = KIND_BIND_ALT;
        end else if (pick < 67) begin
            r.kind = KIND_KEY;
        end else if (pick < 82) begin
            r.kind = KIND_TICK;
        end else if (pick < 96) begin
            r.kind = KIND_QUERY;
        end else begin
            r.kind = 3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
        end
        pick = $urandom_range(0, 19);
        if (pick < 9) begin
            r.press_state = PRESS_DOWN;
        end else if (pick < 18) begin
            r.press_state = PRESS_RELEASE;
        end else begin
            r.press_state = 2'($urandom_range(PRESS_IDLE_FIRST, PRESS_IDLE_LAST));
        end
        return r;
    endfunction

    // Offers one item right after a falling edge and returns at the falling edge after it
    // was taken. The sender works in bursts: when a burst runs out, valid drops for a
    // random gap before the next burst. A gap of zero keeps valid high back to back.
    task automatic offer(input t_in_item req);
        int gap;
        in_valid <= 1'b1;
        in_item  <= req;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
        @(negedge clk);
        sent_count++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = $urandom_range(0, 8);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    // The sender stops until every result item that is owed has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
    endtask

    // A full key tap on one pooled key: press, a flag query, release and two ticks, so the
    // released flag is seen both rising and falling back.
    task automatic key_tap(input int id_span);
        logic [9:0]  k;
        logic [15:0] id;
        k  = key_pool[$urandom_range(0, KEY_POOL - 1)];
        id = id_pool[$urandom_range(0, id_span - 1)];
        offer(make_req(KIND_KEY, id, k, PRESS_DOWN));
        offer(make_req(KIND_QUERY, id, 10'($urandom), 2'($urandom)));
        offer(make_req(KIND_KEY, id, k, PRESS_RELEASE));
        offer(make_req(KIND_TICK, id, 10'($urandom), 2'($urandom)));
        offer(make_req(KIND_TICK, id, 10'($urandom), 2'($urandom)));
    endtask

    task automatic random_phase(input int id_span, input int items);
        phase_end = sent_count + items;
        while (sent_count < phase_end) begin
            if ($urandom_range(0, 9) == 0) begin
                key_tap(id_span);
            end else begin
                offer(random_request(id_span));
            end
        end
    endtask

    // Receiver: ready follows a pattern of its own, in segments of random length. The
    // third segment waits until the sender is well into its first random phase and then
    // holds off for a long stretch, so the block fills and pushes back on the sender;
    // later segments mix steady acceptance, random stalls and short hold-offs.
    initial begin
        int seg;
        int len;
        int mode;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        seg = 0;
        forever begin
            if (seg == 2) begin
                wait (sent_count >= HOLD_OFF_AFTER);
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end else begin
                mode = $urandom_range(0, 9);
                len  = $urandom_range(1, 60);
                repeat (len) begin
                    if (mode < 4) begin
                        out_ready <= 1'b1;
                    end else if (mode < 9) begin
                        out_ready <= 1'($urandom_range(0, 1));
                    end else begin
                        out_ready <= 1'b0;
                    end
                    @(negedge clk);
                end
            end
            seg++;
        end
    end

    // Main sequence: reset, directed requests, then two random phases. The first random
    // phase keeps the id pool small enough that the table never fills; the second opens
    // the whole pool so the table fills and later binds of new actions are refused.
    initial begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_item    = '0;
        burst_left = 1;
        sent_count = 0;
        id_pool[0]  = 16'h0000;
        id_pool[1]  = 16'hFFFF;
        for (int i = 2; i < ID_POOL; i++) begin
            id_pool[i] = 16'($urandom_range(1, 16'hFFFE));
        end
        key_pool[0] = 10'h000;
        key_pool[1] = 10'h3FF;
        for (int i = 2; i < KEY_POOL; i++) begin
            key_pool[i] = 10'($urandom_range(1, 10'h3FE));
        end
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Query of an action that is not in the table reports clear flags.
        offer(make_req(KIND_QUERY, 16'h0000, 10'h000, PRESS_RELEASE));
        // Binding the alternate to the primary's key moves the key off the primary.
        offer(make_req(KIND_BIND_PRI, 16'h0000, 10'h000, PRESS_RELEASE));
        offer(make_req(KIND_BIND_ALT, 16'h0000, 10'h000, PRESS_RELEASE));
        offer(make_req(KIND_BIND_PRI, 16'hFFFF, 10'h3FF, PRESS_DOWN));
        // Takes key 0 from action 0: the displaced id is zero while the flag is set.
        offer(make_req(KIND_BIND_ALT, 16'hFFFF, 10'h000, PRESS_DOWN));
        offer(make_req(KIND_BIND_PRI, 16'h0000, 10'h3FF, PRESS_RELEASE));
        offer(make_req(KIND_KEY, 16'h0000, 10'h3FF, PRESS_DOWN));
        // Press states other than press and release leave the flags alone.
        offer(make_req(KIND_KEY, 16'h0000, 10'h3FF, PRESS_IDLE_FIRST));
        offer(make_req(KIND_KEY, 16'h0000, 10'h3FF, PRESS_IDLE_LAST));
        offer(make_req(KIND_KEY, 16'hFFFF, 10'h000, PRESS_DOWN));
        offer(make_req(KIND_KEY, 16'h0000, 10'h3FF, PRESS_RELEASE));
        offer(make_req(KIND_TICK, 16'h0000, 10'h3FF, PRESS_DOWN));
        offer(make_req(KIND_QUERY, 16'h0000, 10'h3FF, PRESS_DOWN));
        offer(make_req(KIND_TICK, 16'h0000, 10'h3FF, PRESS_DOWN));
        // Unused kinds change nothing but still report the named action's flags.
        offer(make_req(KIND_SPARE_FIRST, 16'hFFFF, 10'h3FF, PRESS_RELEASE));
        offer(make_req(KIND_SPARE_MID, 16'hFFFF, 10'h000, PRESS_RELEASE));
        offer(make_req(KIND_SPARE_LAST, 16'h0000, 10'h3FF, PRESS_RELEASE));
        offer(make_req(KIND_QUERY, 16'h1234, 10'h155, PRESS_DOWN));
        // New entry with only the alternate bound; its primary slot stays unbound.
        offer(make_req(KIND_BIND_ALT, 16'h8000, 10'h200, PRESS_DOWN));
        offer(make_req(KIND_KEY, 16'h8000, 10'h000, PRESS_RELEASE));
        // Key 0 is bound only to this action's alternate, so it moves off that slot and nothing is displaced.
        offer(make_req(KIND_BIND_PRI, 16'hFFFF, 10'h000, PRESS_RELEASE));
        offer(make_req(KIND_QUERY, 16'hFFFF, 10'h000, PRESS_RELEASE));
        drain_results();

        random_phase(NARROW_IDS, RANDOM_ITEMS / 2);
        drain_results();
        random_phase(ID_POOL, RANDOM_ITEMS / 2);

        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("action_key_binding_table_unit_test: PASS");
        end else begin
            $display("action_key_binding_table_unit_test: FAIL");
        end
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial begin
        #800000;
        $display("action_key_binding_table_unit_test: FAIL");
        $finish;
    end

endmodule

### files.f
hw/rtl/akbt_pkg.sv
hw/rtl/akbt_cell.sv
hw/rtl/action_key_binding_table_unit.sv
hw/rtl/akbt_checker.sv
tb/akbt_result_checker.sv
tb/action_key_binding_table_unit_test.sv
